>>> rtl/core/svic_pkg.sv
package svic_pkg;

  // Fixed port widths
  localparam int unsigned XyzW      = 63;
  localparam int unsigned LabelW    = 20;
  localparam int unsigned CauseW    = 4;
  localparam int unsigned EdgeLimW  = 44;
  localparam int unsigned AreaLimW  = 63;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 63;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEdgeLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAreaLimit = 1'd1;

  // Number of checks, one flag each, in priority order
  localparam int unsigned NumChecks = 9;

  typedef enum logic [CauseW-1:0] {
    CauseOk         = 4'd0,
    CauseNextArea   = 4'd1,
    CauseNextEdgeAb = 4'd2,
    CauseNextEdgeCa = 4'd3,
    CauseNextFlip   = 4'd4,
    CausePrevArea   = 4'd5,
    CausePrevEdgeAb = 4'd6,
    CausePrevEdgeCa = 4'd7,
    CausePrevFlip   = 4'd8,
    CauseDisagree   = 4'd9
  } cause_e;

endpackage

>>> rtl/core/svic_wmul.sv
// Two-stage signed multiplier, operands split in halves.
module svic_wmul #(
  parameter int unsigned AW = 45,
  parameter int unsigned BW = 45
) (
  input  logic                    clk_i,
  input  logic                    en1_i,
  input  logic                    en2_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned LA = AW / 2;
  localparam int unsigned LB = BW / 2;
  localparam int unsigned HA = AW - LA;
  localparam int unsigned HB = BW - LB;
  localparam int unsigned PW = AW + BW;

  logic signed [HA-1:0] ah;
  logic signed [HB-1:0] bh;
  logic        [LA-1:0] al;
  logic        [LB-1:0] bl;

  assign ah = $signed(a_i[AW-1:LA]);
  assign bh = $signed(b_i[BW-1:LB]);
  assign al = a_i[LA-1:0];
  assign bl = b_i[LB-1:0];

  logic signed [HA+HB-1:0] pp_hh_q;
  logic signed [HA+LB:0]   pp_hl_q;
  logic signed [LA+HB:0]   pp_lh_q;
  logic        [LA+LB-1:0] pp_ll_q;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      pp_hh_q <= ah * bh;
      pp_hl_q <= ah * $signed({1'b0, bl});
      pp_lh_q <= $signed({1'b0, al}) * bh;
      pp_ll_q <= al * bl;
    end
  end

  logic signed [PW-1:0] t_hh, t_hl, t_lh, t_ll;
  logic signed [PW-1:0] p_d, p_q;

  // high(a) * low(b) carries the weight of a's split, low(a) * high(b) that of b's
  always_comb begin
    t_hh = PW'(pp_hh_q);
    t_hl = PW'(pp_hl_q);
    t_lh = PW'(pp_lh_q);
    t_ll = $signed(PW'(pp_ll_q));
    p_d  = (t_hh <<< (LA + LB)) + (t_hl <<< LA) + (t_lh <<< LB) + t_ll;
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/surface_vertex_inversion_check.sv
// Surface vertex inversion check. Each item is one vertex-face corner; the block
// forms the next triangle (V, N, C) and the previous triangle (V, C, P), takes
// their cross products exactly in fixed point, and tests nine conditions in
// priority order (next area, next edges, next flip against the vertex normal,
// the same for prev, then disagreement of the two triangle normals). The result
// item carries the label, an inverted flag and the first failing cause (0 = ok);
// an inactive corner always reports ok. One item per clock is accepted and one
// result per clock is delivered while the output is not stalled; items pass seven
// register stages: differences, small products, cross products, split partial
// products, full products, sums and compares, and the cause encoder. Every
// stage has its own valid bit and holds only while the stage after it is full
// and stalled, so bubbles are squeezed out under backpressure. The limit
// registers are written through the plain write port: index 0 edge_limit_sq,
// index 1 area_limit_sq, both reset to 1; a limit of 0 never fires.
module surface_vertex_inversion_check
  import svic_pkg::*;
#(
  parameter int unsigned COORD_BITS = 21,
  parameter int unsigned LABEL_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [XyzW-1:0]     vertex_xyz_i,
  input  logic [XyzW-1:0]     next_xyz_i,
  input  logic [XyzW-1:0]     prev_xyz_i,
  input  logic [XyzW-1:0]     centre_xyz_i,
  input  logic [XyzW-1:0]     normal_xyz_i,
  input  logic [LabelW-1:0]   vertex_label_i,
  input  logic                active_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LabelW-1:0]   result_label_o,
  output logic                inverted_o,
  output logic [CauseW-1:0]   cause_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DW  = CB + 1;          // coordinate difference
  localparam int unsigned PW1 = 2 * DW;          // difference product
  localparam int unsigned XW  = PW1 + 1;         // cross product component
  localparam int unsigned QW  = 2 * XW;          // cross times cross
  localparam int unsigned NDW = XW + CB;         // cross times vertex normal
  localparam int unsigned ESW = PW1 + 2;         // edge length sum
  localparam int unsigned ASW = QW + 2;          // area / disagreement sum
  localparam int unsigned NSW = NDW + 2;         // flip dot sum
  localparam int unsigned ECW = (ESW > EdgeLimW) ? ESW : EdgeLimW;
  localparam int unsigned ACW = (ASW > AreaLimW) ? ASW : AreaLimW;
  localparam int unsigned LK  = (LABEL_BITS < LabelW) ? LABEL_BITS : LabelW;
  localparam int unsigned NS  = 7;               // pipeline stages

  // ---------------------------------------------------------------- config
  logic [EdgeLimW-1:0] edge_lim_q;
  logic [AreaLimW-1:0] area_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_lim_q <= EdgeLimW'(1);
      area_lim_q <= AreaLimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEdgeLimit: edge_lim_q <= cfg_data_i[EdgeLimW-1:0];
        CfgAreaLimit: area_lim_q <= cfg_data_i[AreaLimW-1:0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------- stage flow control
  // A stage loads when it is empty or the stage after it moves on.
  logic [NS:1]   v_q, v_d, v_in;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NS-1:1], in_valid_i};
    for (int k = 1; k <= NS; k++) begin
      v_d[k] = en[k] ? v_in[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NS];

  // ------------------------------------------------- stage 1: differences
  // e1 = N - V, e2 = C - V, e3 = P - V
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] e3_q [3];
  logic signed [CB-1:0] pn1_q [3];
  logic [LK-1:0]        lab1_q;
  logic                 act1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k]  <= DW'($signed(next_xyz_i[k*CB +: CB]))
                  - DW'($signed(vertex_xyz_i[k*CB +: CB]));
        e2_q[k]  <= DW'($signed(centre_xyz_i[k*CB +: CB]))
                  - DW'($signed(vertex_xyz_i[k*CB +: CB]));
        e3_q[k]  <= DW'($signed(prev_xyz_i[k*CB +: CB]))
                  - DW'($signed(vertex_xyz_i[k*CB +: CB]));
        pn1_q[k] <= $signed(normal_xyz_i[k*CB +: CB]);
      end
      lab1_q <= vertex_label_i[LK-1:0];
      act1_q <= active_i;
    end
  end

  // ---------------------------------- stage 2: cross terms and edge squares
  logic signed [PW1-1:0] cn_q [6];   // terms of e1 x e2
  logic signed [PW1-1:0] cp_q [6];   // terms of e2 x e3
  logic signed [PW1-1:0] sq_q [9];   // e1^2, e2^2, e3^2 per component
  logic signed [CB-1:0]  pn2_q [3];
  logic [LK-1:0]         lab2_q;
  logic                  act2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      cn_q[0] <= e1_q[1] * e2_q[2];
      cn_q[1] <= e1_q[2] * e2_q[1];
      cn_q[2] <= e1_q[2] * e2_q[0];
      cn_q[3] <= e1_q[0] * e2_q[2];
      cn_q[4] <= e1_q[0] * e2_q[1];
      cn_q[5] <= e1_q[1] * e2_q[0];
      cp_q[0] <= e2_q[1] * e3_q[2];
      cp_q[1] <= e2_q[2] * e3_q[1];
      cp_q[2] <= e2_q[2] * e3_q[0];
      cp_q[3] <= e2_q[0] * e3_q[2];
      cp_q[4] <= e2_q[0] * e3_q[1];
      cp_q[5] <= e2_q[1] * e3_q[0];
      for (int k = 0; k < 3; k++) begin
        sq_q[k]     <= e1_q[k] * e1_q[k];
        sq_q[3 + k] <= e2_q[k] * e2_q[k];
        sq_q[6 + k] <= e3_q[k] * e3_q[k];
        pn2_q[k]    <= pn1_q[k];
      end
      lab2_q <= lab1_q;
      act2_q <= act1_q;
    end
  end

  // ----------------------------- stage 3: cross products and edge compares
  logic [ESW-1:0]       esum [3];
  logic [2:0]           edge_hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      esum[i]     = ESW'(sq_q[3*i]) + ESW'(sq_q[3*i + 1]) + ESW'(sq_q[3*i + 2]);
      edge_hit[i] = ECW'(esum[i]) < ECW'(edge_lim_q);
    end
  end

  logic signed [XW-1:0] nn_q [3];
  logic signed [XW-1:0] np_q [3];
  logic signed [CB-1:0] pn3_q [3];
  logic [2:0]           edge3_q;
  logic [LK-1:0]        lab3_q;
  logic                 act3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        nn_q[k]  <= XW'(cn_q[2*k]) - XW'(cn_q[2*k + 1]);
        np_q[k]  <= XW'(cp_q[2*k]) - XW'(cp_q[2*k + 1]);
        pn3_q[k] <= pn2_q[k];
      end
      edge3_q <= edge_hit;
      lab3_q  <= lab2_q;
      act3_q  <= act2_q;
    end
  end

  // --------------------------------- stages 4 and 5: wide products, split
  logic signed [QW-1:0]  sqn [3];   // nNext squared
  logic signed [QW-1:0]  sqp [3];   // nPrev squared
  logic signed [QW-1:0]  dnp [3];   // nNext * nPrev
  logic signed [NDW-1:0] dnv [3];   // nNext * vertex normal
  logic signed [NDW-1:0] dpv [3];   // nPrev * vertex normal

  for (genvar k = 0; k < 3; k++) begin : g_prod
    svic_wmul #(.AW(XW), .BW(XW)) u_sqn (
      .clk_i(clk_i), .en1_i(en[4]), .en2_i(en[5]),
      .a_i(nn_q[k]), .b_i(nn_q[k]), .p_o(sqn[k])
    );
    svic_wmul #(.AW(XW), .BW(XW)) u_sqp (
      .clk_i(clk_i), .en1_i(en[4]), .en2_i(en[5]),
      .a_i(np_q[k]), .b_i(np_q[k]), .p_o(sqp[k])
    );
    svic_wmul #(.AW(XW), .BW(XW)) u_dnp (
      .clk_i(clk_i), .en1_i(en[4]), .en2_i(en[5]),
      .a_i(nn_q[k]), .b_i(np_q[k]), .p_o(dnp[k])
    );
    svic_wmul #(.AW(XW), .BW(CB)) u_dnv (
      .clk_i(clk_i), .en1_i(en[4]), .en2_i(en[5]),
      .a_i(nn_q[k]), .b_i(pn3_q[k]), .p_o(dnv[k])
    );
    svic_wmul #(.AW(XW), .BW(CB)) u_dpv (
      .clk_i(clk_i), .en1_i(en[4]), .en2_i(en[5]),
      .a_i(np_q[k]), .b_i(pn3_q[k]), .p_o(dpv[k])
    );
  end

  logic [2:0]    edge4_q, edge5_q;
  logic [LK-1:0] lab4_q, lab5_q;
  logic          act4_q, act5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      edge4_q <= edge3_q;
      lab4_q  <= lab3_q;
      act4_q  <= act3_q;
    end
    if (en[5]) begin
      edge5_q <= edge4_q;
      lab5_q  <= lab4_q;
      act5_q  <= act4_q;
    end
  end

  // ---------------------------------------- stage 6: sums and check flags
  logic [ASW-1:0]        area_n, area_p;
  logic signed [ASW-1:0] dis_sum;
  logic signed [NSW-1:0] flip_n, flip_p;
  logic [NumChecks-1:0]  flags_d;

  always_comb begin
    area_n  = ASW'(sqn[0]) + ASW'(sqn[1]) + ASW'(sqn[2]);
    area_p  = ASW'(sqp[0]) + ASW'(sqp[1]) + ASW'(sqp[2]);
    dis_sum = ASW'(dnp[0]) + ASW'(dnp[1]) + ASW'(dnp[2]);
    flip_n  = NSW'(dnv[0]) + NSW'(dnv[1]) + NSW'(dnv[2]);
    flip_p  = NSW'(dpv[0]) + NSW'(dpv[1]) + NSW'(dpv[2]);
    // bit i flags cause i+1; edges V-C and C-V share one test
    flags_d[0] = ACW'(area_n) < ACW'(area_lim_q);
    flags_d[1] = edge5_q[0];
    flags_d[2] = edge5_q[1];
    flags_d[3] = flip_n[NSW-1];
    flags_d[4] = ACW'(area_p) < ACW'(area_lim_q);
    flags_d[5] = edge5_q[1];
    flags_d[6] = edge5_q[2];
    flags_d[7] = flip_p[NSW-1];
    flags_d[8] = dis_sum[ASW-1];
    flags_d    = flags_d & {NumChecks{act5_q}};
  end

  logic [NumChecks-1:0] flags_q;
  logic [LK-1:0]        lab6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      flags_q <= flags_d;
      lab6_q  <= lab5_q;
    end
  end

  // ------------------------------------------ stage 7: first failing cause
  cause_e cause_d, cause_q;
  logic   inverted_q;
  logic [LK-1:0] lab7_q;

  always_comb begin
    cause_d = CauseOk;
    for (int i = NumChecks - 1; i >= 0; i--) begin
      if (flags_q[i]) begin
        cause_d = cause_e'(CauseW'(i + 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      cause_q    <= cause_d;
      inverted_q <= |flags_q;
      lab7_q     <= lab6_q;
    end
  end

  assign result_label_o = LabelW'(lab7_q);
  assign inverted_o     = inverted_q;
  assign cause_o        = cause_q;

  // ------------------------------------------------------------- checks
  // An empty output stage never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // The input stalls only when every stage is full and the output is stalled.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&v_q) && !out_ready_i))
    else $error("input stalled with a bubble in the pipeline");

  // Inverted flag and cause agree.
  a_flag_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inverted_o == (cause_o != CauseOk)))
    else $error("inverted flag disagrees with cause");

endmodule

>>> test/tb_surface_vertex_inversion_check.sv
module tb_surface_vertex_inversion_check;
  timeunit 1ns;
  timeprecision 1ps;

  import svic_pkg::*;

  localparam int unsigned CoordW     = 21;
  localparam int unsigned Latency    = 7;
  localparam int unsigned IdleLimit  = 1000;  // cycles with no handshake on either side
  localparam int unsigned MaxReports = 10;
  localparam int          CoordMax   = (1 << (CoordW - 1)) - 1;
  localparam int          CoordMin   = -(1 << (CoordW - 1));

  // Stimulus side vectors: plain ints, wrapped to 21 bits when packed.
  typedef struct { int x; int y; int z; } ivec_t;
  // Predictor side vectors: wide enough for exact cross products.
  typedef struct { longint x; longint y; longint z; } lvec_t;

  typedef struct {
    logic [XyzW-1:0]   vertex;
    logic [XyzW-1:0]   next;
    logic [XyzW-1:0]   prev;
    logic [XyzW-1:0]   centre;
    logic [XyzW-1:0]   normal;
    logic [LabelW-1:0] label;
    logic              active;
  } corner_t;

  typedef struct {
    logic [LabelW-1:0] label;
    logic              inverted;
    cause_e            cause;
  } verdict_t;

  // DUT ports
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [XyzW-1:0]     vertex_xyz_i;
  logic [XyzW-1:0]     next_xyz_i;
  logic [XyzW-1:0]     prev_xyz_i;
  logic [XyzW-1:0]     centre_xyz_i;
  logic [XyzW-1:0]     normal_xyz_i;
  logic [LabelW-1:0]   vertex_label_i;
  logic                active_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [LabelW-1:0]   result_label_o;
  logic                inverted_o;
  logic [CauseW-1:0]   cause_o;

  // Shadow copies of the limit registers, as the block should hold them.
  logic [EdgeLimW-1:0] edge_lim = 44'd1;
  logic [AreaLimW-1:0] area_lim = 63'd1;

  corner_t     corner_q[$];   // corners waiting to be sent
  verdict_t    verdict_q[$];  // verdicts owed by the block, oldest first
  bit          in_taken;      // input item accepted at the last rising edge
  bit          out_taken;     // result item accepted at the last rising edge
  bit          burst;         // no gaps and no stalls while set
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned err_cnt;
  int unsigned idle_cycles;

  surface_vertex_inversion_check u_top (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact integer geometry, first failing check wins
  // ---------------------------------------------------------------------------

  function automatic lvec_t unpack_xyz(logic [XyzW-1:0] p);
    lvec_t r;
    r.x = longint'($signed(p[CoordW-1:0]));
    r.y = longint'($signed(p[2*CoordW-1:CoordW]));
    r.z = longint'($signed(p[3*CoordW-1:2*CoordW]));
    return r;
  endfunction

  function automatic lvec_t vdiff(lvec_t a, lvec_t b);
    lvec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  // Differences are at most 22 bits, so each component fits in 45 bits.
  function automatic lvec_t vcross3(lvec_t a, lvec_t b);
    lvec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // Cross . cross needs about 92 bits; 128 keeps every sign exact.
  function automatic logic signed [127:0] vdot3(lvec_t a, lvec_t b);
    logic signed [127:0] ax, ay, az, bx, by, bz;
    ax = a.x;
    ay = a.y;
    az = a.z;
    bx = b.x;
    by = b.y;
    bz = b.z;
    return ax * bx + ay * by + az * bz;
  endfunction

  function automatic logic area_small(lvec_t n);
    logic signed [127:0] sq;
    sq = vdot3(n, n);
    return $unsigned(sq) < {65'd0, area_lim};
  endfunction

  // Squared edge is below 2^44, no overflow in 64 bits.
  function automatic logic edge_small(lvec_t d);
    logic [63:0] sq;
    sq = d.x * d.x + d.y * d.y + d.z * d.z;
    return sq < {20'd0, edge_lim};
  endfunction

  function automatic cause_e first_fault(corner_t c);
    lvec_t v, nx, pv, ct, nm, n_next, n_prev;
    if (!c.active) return CauseOk;
    v  = unpack_xyz(c.vertex);
    nx = unpack_xyz(c.next);
    pv = unpack_xyz(c.prev);
    ct = unpack_xyz(c.centre);
    nm = unpack_xyz(c.normal);
    n_next = vcross3(vdiff(nx, v), vdiff(ct, v));
    n_prev = vcross3(vdiff(ct, v), vdiff(pv, v));
    if (area_small(n_next))           return CauseNextArea;
    if (edge_small(vdiff(v, nx)))     return CauseNextEdgeAb;
    if (edge_small(vdiff(ct, v)))     return CauseNextEdgeCa;
    if (vdot3(n_next, nm) < 0)        return CauseNextFlip;
    if (area_small(n_prev))           return CausePrevArea;
    if (edge_small(vdiff(v, ct)))     return CausePrevEdgeAb;  // mirrors the next-side edge
    if (edge_small(vdiff(pv, v)))     return CausePrevEdgeCa;
    if (vdot3(n_prev, nm) < 0)        return CausePrevFlip;
    if (vdot3(n_next, n_prev) < 0)    return CauseDisagree;
    return CauseOk;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [XyzW-1:0] pack_xyz(ivec_t a);
    logic [CoordW-1:0] px, py, pz;
    px = a.x[CoordW-1:0];
    py = a.y[CoordW-1:0];
    pz = a.z[CoordW-1:0];
    return {pz, py, px};
  endfunction

  function automatic int spread(int k);
    return int'($urandom_range(0, 2 * k)) - k;
  endfunction

  function automatic ivec_t vadd(ivec_t a, ivec_t b);
    return '{a.x + b.x, a.y + b.y, a.z + b.z};
  endfunction

  function automatic longint cross_z(ivec_t a, ivec_t b);
    return longint'(a.x) * b.y - longint'(a.y) * b.x;
  endfunction

  function automatic ivec_t jitter_vec();
    return '{spread(1), spread(1), spread(1)};
  endfunction

  // Corner values of the coordinate range, mixed with plain random ones.
  function automatic ivec_t edge_vec();
    ivec_t r;
    int    k[3];
    foreach (k[i]) begin
      case ($urandom_range(0, 4))
        0: k[i] = CoordMin;
        1: k[i] = CoordMax;
        2: k[i] = 0;
        3: k[i] = -1;
        default: k[i] = int'($urandom_range(0, (1 << CoordW) - 1)) + CoordMin;
      endcase
    end
    r = '{k[0], k[1], k[2]};
    return r;
  endfunction

  function automatic logic [XyzW-1:0] rand_raw();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[XyzW-1:0];
  endfunction

  // Mostly well-formed corners: N, C, P wound counterclockwise around V in
  // a near-flat patch with the normal pointing up, then one defect or none.
  function automatic corner_t make_corner();
    corner_t     c;
    ivec_t       v, d1, d2, d3, nrm;
    int          m, lim;
    int unsigned kind;
    kind     = $urandom_range(0, 9);
    c.label  = LabelW'($urandom);
    c.active = ($urandom_range(0, 9) != 0);
    if (kind == 0) begin
      c.vertex = rand_raw();
      c.next   = rand_raw();
      c.prev   = rand_raw();
      c.centre = rand_raw();
      c.normal = rand_raw();
      return c;
    end
    if (kind == 1) begin
      c.vertex = pack_xyz(edge_vec());
      c.next   = pack_xyz(edge_vec());
      c.prev   = pack_xyz(edge_vec());
      c.centre = pack_xyz(edge_vec());
      c.normal = pack_xyz(edge_vec());
      return c;
    end
    m   = 1 << $urandom_range(1, 18);
    lim = (1 << (CoordW - 1)) - 4 * m;  // room for V + 2*offset
    v   = '{spread(lim), spread(lim), spread(lim)};
    d1  = '{spread(m), spread(m), spread(m >> 3)};
    d2  = '{spread(m), spread(m), spread(m >> 3)};
    if (cross_z(d1, d2) < 0) begin
      d2.x = -d2.x;
      d2.y = -d2.y;
    end
    d3 = '{spread(m), spread(m), spread(m >> 3)};
    if (cross_z(d2, d3) < 0) begin
      d3.x = -d3.x;
      d3.y = -d3.y;
    end
    nrm = '{spread(m), spread(m), int'($urandom_range(1, CoordMax))};
    case ($urandom_range(0, 11))
      0: d1 = jitter_vec();                       // N on top of V
      1: d2 = jitter_vec();                       // C on top of V
      2: d3 = jitter_vec();                       // P on top of V
      3: nrm = '{-nrm.x, -nrm.y, -nrm.z};         // normal points down
      4: nrm = '{0, 0, 0};                        // zero normal
      5: d3 = '{-d2.x, -d2.y, -d2.z};             // P, V, C collinear
      6: begin                                    // P folded over
        d3.x = -d3.x;
        d3.y = -d3.y;
      end
      7: d1 = '{2 * d2.x, 2 * d2.y, 2 * d2.z};    // N, V, C collinear
      default: ;
    endcase
    c.vertex = pack_xyz(v);
    c.next   = pack_xyz(vadd(v, d1));
    c.centre = pack_xyz(vadd(v, d2));
    c.prev   = pack_xyz(vadd(v, d3));
    c.normal = pack_xyz(nrm);
    return c;
  endfunction

  task automatic add_corner(ivec_t v, ivec_t n, ivec_t p, ivec_t c, ivec_t nrm,
                            logic [LabelW-1:0] label, logic active);
    corner_t item;
    item.vertex = pack_xyz(v);
    item.next   = pack_xyz(n);
    item.prev   = pack_xyz(p);
    item.centre = pack_xyz(c);
    item.normal = pack_xyz(nrm);
    item.label  = label;
    item.active = active;
    corner_q.push_back(item);
  endtask

  // Wait until the sender is empty and every owed verdict has arrived,
  // then let the pipeline run dry.
  task automatic wait_idle();
    while (corner_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgEdgeLimit) edge_lim = data[EdgeLimW-1:0];
    else area_lim = data[AreaLimW-1:0];
  endtask

  task automatic set_limits(logic [CfgDataW-1:0] edge_data, logic [CfgDataW-1:0] area_data);
    write_reg(CfgEdgeLimit, edge_data);
    write_reg(CfgAreaLimit, area_data);
  endtask

  // Random corners in chunks; between chunks the sender sometimes holds off
  // until the block has drained completely.
  task automatic run_random(int unsigned count);
    int unsigned done_cnt, chunk;
    done_cnt = 0;
    while (done_cnt < count) begin
      chunk = $urandom_range(20, 150);
      if (chunk > count - done_cnt) chunk = count - done_cnt;
      burst = ($urandom_range(0, 3) == 0);
      repeat (chunk) corner_q.push_back(make_corner());
      while (corner_q.size() != 0) @(posedge clk_i);
      if ($urandom_range(0, 2) == 0) wait_idle();
      done_cnt += chunk;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge, one item per handshake,
  // a random gap drawn after each accepted item.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    corner_t item;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_taken) in_gap = burst ? 0 : $urandom_range(0, 3);
      if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (corner_q.size() != 0) begin
        item = corner_q.pop_front();
        vertex_xyz_i   <= item.vertex;
        next_xyz_i     <= item.next;
        prev_xyz_i     <= item.prev;
        centre_xyz_i   <= item.centre;
        normal_xyz_i   <= item.normal;
        vertex_label_i <= item.label;
        active_i       <= item.active;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side backpressure: a random stall drawn after each result.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_stall = burst ? 0 : $urandom_range(0, 3);
      if (out_stall != 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sampled at the rising edge. Accepted corners are predicted
  // right away; accepted results are checked against the oldest verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    corner_t  seen;
    verdict_t want;
    in_taken  = rst_ni && in_valid_i && in_ready_o;
    out_taken = rst_ni && out_valid_o && out_ready_i;
    if (in_taken) begin
      seen.vertex    = vertex_xyz_i;
      seen.next      = next_xyz_i;
      seen.prev      = prev_xyz_i;
      seen.centre    = centre_xyz_i;
      seen.normal    = normal_xyz_i;
      seen.label     = vertex_label_i;
      seen.active    = active_i;
      want.label     = vertex_label_i;
      want.cause     = first_fault(seen);
      want.inverted  = (want.cause != CauseOk);
      verdict_q.push_back(want);
    end
    if (out_taken) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: result with none owed: label %h inverted %b cause %0d",
                   $time, result_label_o, inverted_o, cause_o);
      end else begin
        want = verdict_q.pop_front();
        if (result_label_o !== want.label || inverted_o !== want.inverted ||
            cause_o !== want.cause) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: mismatch: exp label %h inv %b cause %0d, got label %h inv %b cause %0d",
                     $time, want.label, want.inverted, want.cause,
                     result_label_o, inverted_o, cause_o);
        end
      end
    end
  end

  // Watchdog: a stuck handshake on both sides ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no handshake for %0d cycles", $time, IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    ivec_t   org, ax, ay, axy, up, down, ones;
    corner_t junk;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgEdgeLimit;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    vertex_xyz_i   = '0;
    next_xyz_i     = '0;
    prev_xyz_i     = '0;
    centre_xyz_i   = '0;
    normal_xyz_i   = '0;
    vertex_label_i = '0;
    active_i       = 1'b0;
    out_ready_i    = 1'b0;
    rst_ni         = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unit square corner: V at origin, N on x, C diagonal, P on y.
    org  = '{0, 0, 0};
    ax   = '{100, 0, 0};
    ay   = '{0, 100, 0};
    axy  = '{100, 100, 0};
    up   = '{0, 0, 1};
    down = '{0, 0, -1};
    ones = '{-1, -1, -1};

    // Reset limits (1, 1): only exact zeros count as degenerate.
    add_corner(org, org, org, org, org, '0, 1'b1);                // all zero: next area
    add_corner(ones, ones, ones, ones, ones, '1, 1'b1);           // all bits set
    add_corner(ones, ones, ones, ones, ones, '1, 1'b0);           // inactive corner
    junk = make_corner();
    junk.active = 1'b0;
    corner_q.push_back(junk);                                     // inactive, random content
    add_corner(org, ax, ay, axy, up, 20'h5a5a5, 1'b1);            // clean corner
    add_corner(org, ax, ay, axy, down, 20'ha5a5a, 1'b1);          // next triangle flipped
    add_corner(org, ax, '{-100, -100, 0}, axy, up, 20'h00001, 1'b1);  // prev degenerate
    add_corner(org, ax, ax, axy, up, 20'h80000, 1'b1);            // prev flipped
    add_corner(org, ax, ax, axy, org, 20'h7ffff, 1'b1);           // zero normal, disagree
    add_corner(org, ax, ay, axy, org, 20'h12345, 1'b1);           // zero normal passes
    // Full-range extremes, cross products near 2^84 in squared size.
    add_corner('{CoordMin, CoordMin, CoordMin}, '{CoordMax, CoordMin, CoordMin},
               '{CoordMin, CoordMax, CoordMin}, '{CoordMax, CoordMax, CoordMin},
               '{CoordMax, CoordMax, CoordMax}, '1, 1'b1);
    add_corner('{CoordMax, CoordMax, CoordMax}, '{CoordMin, CoordMax, CoordMax},
               '{CoordMax, CoordMin, CoordMax}, '{CoordMin, CoordMin, CoordMax},
               '{CoordMin, CoordMin, CoordMin}, '0, 1'b1);
    add_corner('{CoordMin, CoordMax, CoordMin}, '{CoordMax, CoordMin, CoordMax},
               '{CoordMax, CoordMax, CoordMax}, '{CoordMin, CoordMin, CoordMax},
               '{CoordMax, CoordMin, CoordMax}, 20'hfffff, 1'b1);
    run_random(200);
    wait_idle();

    // Area check off: the edge checks become visible.
    set_limits(63'd1, 63'd0);
    add_corner(org, org, ay, axy, up, 20'h00010, 1'b1);           // N on V
    add_corner(org, ax, ay, org, up, 20'h00020, 1'b1);            // C on V
    add_corner(org, ax, org, axy, up, 20'h00040, 1'b1);           // P on V
    add_corner(org, org, org, org, org, 20'h00080, 1'b1);
    run_random(250);
    wait_idle();

    // Largest limits: every edge and most areas count as short.
    set_limits({CfgDataW{1'b1}}, {CfgDataW{1'b1}});
    run_random(200);
    wait_idle();

    // Random limit settings of random magnitude.
    repeat (4) begin
      set_limits(rand_raw() >> $urandom_range(0, 62), rand_raw() >> $urandom_range(0, 62));
      run_random(200);
      wait_idle();
    end

    // Both limits zero: no area or edge check can fire.
    set_limits(63'd0, 63'd0);
    add_corner(org, org, org, org, org, 20'h00100, 1'b1);
    add_corner(org, org, ay, axy, up, 20'h00200, 1'b1);
    run_random(200);
    wait_idle();

    set_limits(63'd1, 63'd1);
    run_random(200);
    wait_idle();

    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/svic_pkg.sv
rtl/core/svic_wmul.sv
rtl/core/surface_vertex_inversion_check.sv
test/tb_surface_vertex_inversion_check.sv
